// File: sv/rrq_pkg.sv
// Package for the round-robin run queue: sizes, request and status codes,
// transaction structs and the mark-store command structs.
// No dependencies.
package rrq_pkg;

  localparam int MAX_THREADS = 64;
  localparam int TID_W       = 6;
  localparam int IDX_W       = $clog2(MAX_THREADS);
  localparam int STEP_W      = $clog2(MAX_THREADS + 1);

  // request kinds
  localparam logic [1:0] KIND_NEXT   = 2'd0;
  localparam logic [1:0] KIND_RETURN = 2'd1;
  localparam logic [1:0] KIND_ADD    = 2'd2;
  localparam logic [1:0] KIND_REMOVE = 2'd3;

  // result status codes
  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_NOT_SCHED = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_QUEUED    = 3'd4;

  typedef struct packed {
    logic [1:0]       kind;
    logic [TID_W-1:0] thread_id;
  } in_item_t;

  typedef struct packed {
    logic             has_thread;
    logic [TID_W-1:0] out_thread;
    logic [2:0]       status;
  } out_item_t;

  // write commands into the scheduled/queued mark store
  typedef struct packed {
    logic             sched_we;
    logic             sched_val;
    logic             queued_we;
    logic [IDX_W-1:0] queued_idx;
    logic             queued_val;
  } mark_wr_t;

  // mark bits of the thread under work
  typedef struct packed {
    logic sched;
    logic queued;
  } mark_rd_t;

endpackage

// File: sv/rrq_marks.sv
// Scheduled and queued mark bits, one per thread, cleared by reset.
// Depends on rrq_pkg.
module rrq_marks (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [rrq_pkg::IDX_W-1:0] rd_idx,
  input  rrq_pkg::mark_wr_t        wr,
  output rrq_pkg::mark_rd_t        rd
);

  logic [rrq_pkg::MAX_THREADS-1:0] sched_bits;
  logic [rrq_pkg::MAX_THREADS-1:0] queued_bits;

  // scheduled mark is always written at the thread under work
  always_ff @(posedge clk) begin
    if (rst) begin
      sched_bits <= '0;
    end else if (wr.sched_we) begin
      sched_bits[rd_idx] <= wr.sched_val;
    end
  end

  // queued mark is written at the head on a pop, else at the thread under work
  always_ff @(posedge clk) begin
    if (rst) begin
      queued_bits <= '0;
    end else if (wr.queued_we) begin
      queued_bits[wr.queued_idx] <= wr.queued_val;
    end
  end

  assign rd.sched  = sched_bits[rd_idx];
  assign rd.queued = queued_bits[rd_idx];

endmodule

// File: sv/rrq_engine.sv
// Request sequencer for the run queue: link memory, head/tail registers
// and the list walk used by remove.
// Depends on rrq_pkg and rrq_marks.
module rrq_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  rrq_pkg::in_item_t  req,
  output logic               idle,
  output logic               res_valid,
  input  logic               res_ready,
  output rrq_pkg::out_item_t res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_POPW  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_WALKW = 3'd4;
  localparam logic [2:0] S_UNLW  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                   state, state_next;
  logic [1:0]                   kind_r, kind_r_next;
  logic [rrq_pkg::TID_W-1:0]    tid_r, tid_r_next;
  logic [rrq_pkg::IDX_W-1:0]    head, head_next;
  logic [rrq_pkg::IDX_W-1:0]    tail, tail_next;
  logic                         nonempty, nonempty_next;
  logic [rrq_pkg::IDX_W-1:0]    prev, prev_next;
  logic [rrq_pkg::STEP_W-1:0]   step, step_next;
  rrq_pkg::out_item_t           res_r, res_r_next;

  // link memory: one read port with registered data, one write port
  logic [rrq_pkg::IDX_W-1:0] link_mem [rrq_pkg::MAX_THREADS];
  logic                      rd_en;
  logic [rrq_pkg::IDX_W-1:0] rd_addr;
  logic [rrq_pkg::IDX_W-1:0] rd_data;
  logic                      wr_en;
  logic [rrq_pkg::IDX_W-1:0] wr_addr;
  logic [rrq_pkg::IDX_W-1:0] wr_data;

  rrq_pkg::mark_wr_t         mwr;
  rrq_pkg::mark_rd_t         mrd;
  logic [rrq_pkg::IDX_W-1:0] tidx;
  logic                      in_range;

  assign tidx     = tid_r[rrq_pkg::IDX_W-1:0];
  assign in_range = 32'(tid_r) < 32'(rrq_pkg::MAX_THREADS);

  rrq_marks u_marks (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (tidx),
    .wr     (mwr),
    .rd     (mrd)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= link_mem[rd_addr];
    end
  end

  // sequencer
  always_comb begin
    state_next    = state;
    kind_r_next   = kind_r;
    tid_r_next    = tid_r;
    head_next     = head;
    tail_next     = tail;
    nonempty_next = nonempty;
    prev_next     = prev;
    step_next     = step;
    res_r_next    = res_r;
    rd_en         = 1'b0;
    rd_addr       = head;
    wr_en         = 1'b0;
    wr_addr       = tail;
    wr_data       = tidx;
    mwr           = '0;
    mwr.queued_idx = tidx;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          kind_r_next = req.kind;
          tid_r_next  = req.thread_id;
          state_next  = S_EXEC;
        end
      end

      S_EXEC: begin
        res_r_next = '{has_thread: 1'b0, out_thread: '0, status: rrq_pkg::ST_DONE};
        state_next = S_DONE;
        if (kind_r == rrq_pkg::KIND_NEXT) begin
          if (!nonempty) begin
            res_r_next.status = rrq_pkg::ST_EMPTY;
          end else begin
            res_r_next.has_thread = 1'b1;
            res_r_next.out_thread = rrq_pkg::TID_W'(head);
            mwr.queued_we  = 1'b1;
            mwr.queued_idx = head;
            if (head == tail) begin
              nonempty_next = 1'b0;
              head_next     = '0;
              tail_next     = '0;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = head;
              state_next = S_POPW;
            end
          end
        end else if (!in_range) begin
          res_r_next.status = rrq_pkg::ST_NOT_FOUND;
        end else if (kind_r == rrq_pkg::KIND_RETURN) begin
          if (!mrd.sched) begin
            res_r_next.status = rrq_pkg::ST_NOT_SCHED;
          end else if (mrd.queued) begin
            res_r_next.status = rrq_pkg::ST_QUEUED;
          end else begin
            if (!nonempty) begin
              head_next     = tidx;
              nonempty_next = 1'b1;
            end else begin
              wr_en   = 1'b1;
              wr_addr = tail;
              wr_data = tidx;
            end
            tail_next      = tidx;
            mwr.queued_we  = 1'b1;
            mwr.queued_val = 1'b1;
          end
        end else if (kind_r == rrq_pkg::KIND_ADD) begin
          if (mrd.queued) begin
            res_r_next.status = rrq_pkg::ST_QUEUED;
          end else begin
            mwr.sched_we  = 1'b1;
            mwr.sched_val = 1'b1;
            if (!nonempty) begin
              tail_next     = tidx;
              nonempty_next = 1'b1;
            end else begin
              wr_en   = 1'b1;
              wr_addr = tidx;
              wr_data = head;
            end
            head_next      = tidx;
            mwr.queued_we  = 1'b1;
            mwr.queued_val = 1'b1;
          end
        end else begin
          // remove: unschedule, then unlink if present
          mwr.sched_we = 1'b1;
          if (!nonempty || !mrd.queued) begin
            res_r_next.status = rrq_pkg::ST_NOT_FOUND;
          end else if (tidx == head) begin
            mwr.queued_we = 1'b1;
            if (head == tail) begin
              nonempty_next = 1'b0;
              head_next     = '0;
              tail_next     = '0;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = tidx;
              state_next = S_POPW;
            end
          end else begin
            prev_next  = head;
            step_next  = '0;
            state_next = S_WALK;
          end
        end
      end

      // successor of the old head arrives
      S_POPW: begin
        head_next  = rd_data;
        state_next = S_DONE;
      end

      // one walk step: stop at the tail or at the step bound
      S_WALK: begin
        if (prev == tail || step == rrq_pkg::STEP_W'(rrq_pkg::MAX_THREADS)) begin
          res_r_next.status = rrq_pkg::ST_NOT_FOUND;
          state_next        = S_DONE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = prev;
          state_next = S_WALKW;
        end
      end

      S_WALKW: begin
        step_next = step + 1'b1;
        if (rd_data == tidx) begin
          if (tidx == tail) begin
            tail_next     = prev;
            mwr.queued_we = 1'b1;
            state_next    = S_DONE;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = tidx;
            state_next = S_UNLW;
          end
        end else begin
          prev_next  = rd_data;
          state_next = S_WALK;
        end
      end

      // splice predecessor past the removed thread
      S_UNLW: begin
        wr_en         = 1'b1;
        wr_addr       = prev;
        wr_data       = rd_data;
        mwr.queued_we = 1'b1;
        state_next    = S_DONE;
      end

      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      tail     <= '0;
      nonempty <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      tail     <= tail_next;
      nonempty <= nonempty_next;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_r_next;
    tid_r  <= tid_r_next;
    prev   <= prev_next;
    step   <= step_next;
    res_r  <= res_r_next;
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = res_r;

  // an empty queue keeps head and tail parked at zero
  a_empty_parked: assert property (@(posedge clk) disable iff (rst)
    !nonempty |-> (head == '0 && tail == '0))
    else $error("empty queue with nonzero head or tail");

  // link writes only happen on the last step of a request
  a_write_last: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> state == S_DONE)
    else $error("link write not followed by result");

  // every link read is consumed in the following cycle
  a_read_used: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> (state == S_POPW || state == S_WALKW || state == S_UNLW))
    else $error("link read data dropped");

  // walk never runs past its bound
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> 32'(step) <= 32'(rrq_pkg::MAX_THREADS))
    else $error("walk step count overflow");

endmodule

// File: sv/round_robin_run_queue.sv
// Round-robin run queue top level: input handshake and result register.
// A request passes through the sequencer's execute state and done state into the
// output register; take-next or head removal adds a wait for the head's successor,
// and removal deeper in the list adds a read and a wait state per link walked, plus
// a splice state for an inner thread or a last walk check on a miss.
// A new transaction is accepted only while the sequencer is idle, so it is not taken
// before the result of the last one has left the done state.
// Reset: synchronous; empties the queue and clears all marks at once.
module round_robin_run_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rrq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rrq_pkg::out_item_t out_data
);

  logic               eng_idle;
  logic               res_valid;
  logic               res_ready;
  rrq_pkg::out_item_t res;

  assign in_ready = eng_idle;

  rrq_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && eng_idle),
    .req       (in_data),
    .idle      (eng_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register; frees the sequencer while a result waits
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the round-robin run queue: random and directed
// add/return/remove/take-next transactions checked against a scoreboard model.
// Depends on rrq_pkg and round_robin_run_queue.
`timescale 1ns / 100ps

module tb_top;

  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TAIL_CYCLES  = 200;

  typedef struct {
    rrq_pkg::in_item_t req;
    bit                drain;  // hold until every outstanding result is back
  } request_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  rrq_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  rrq_pkg::out_item_t out_data;

  request_t           requests[$];
  rrq_pkg::out_item_t due_results[$];
  int                 total_requests = 0;
  int                 accepted = 0;
  int                 errors = 0;
  int                 cycles = 0;
  int                 in_gap = 0;
  int                 out_stall = 0;
  bit                 in_steady = 1'b0;
  bit                 out_steady = 1'b0;

  // scoreboard copy of the run queue state
  logic [rrq_pkg::TID_W-1:0] link_mem[rrq_pkg::MAX_THREADS];
  bit                        sched_mark[rrq_pkg::MAX_THREADS];
  bit                        queued_mark[rrq_pkg::MAX_THREADS];
  logic [rrq_pkg::TID_W-1:0] head_id = '0;
  logic [rrq_pkg::TID_W-1:0] tail_id = '0;
  bit                        not_empty = 1'b0;

  round_robin_run_queue uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one request to the scoreboard state and return its result
  function automatic rrq_pkg::out_item_t run_queue_step(rrq_pkg::in_item_t req);
    rrq_pkg::out_item_t        res;
    logic [rrq_pkg::TID_W-1:0] t;
    logic [rrq_pkg::TID_W-1:0] prev;
    logic [rrq_pkg::TID_W-1:0] nx;
    res = '0;
    res.status = rrq_pkg::ST_DONE;
    t = req.thread_id;
    case (req.kind)
      rrq_pkg::KIND_NEXT: begin
        if (!not_empty) begin
          res.status = rrq_pkg::ST_EMPTY;
        end else begin
          res.has_thread = 1'b1;
          res.out_thread = head_id;
          queued_mark[head_id] = 1'b0;
          if (head_id == tail_id) begin
            not_empty = 1'b0;
            head_id = '0;
            tail_id = '0;
          end else begin
            head_id = link_mem[head_id];
          end
        end
      end
      rrq_pkg::KIND_RETURN: begin
        if (!sched_mark[t]) begin
          res.status = rrq_pkg::ST_NOT_SCHED;
        end else if (queued_mark[t]) begin
          res.status = rrq_pkg::ST_QUEUED;
        end else begin
          if (!not_empty) begin
            head_id = t;
            not_empty = 1'b1;
          end else begin
            link_mem[tail_id] = t;
          end
          tail_id = t;
          queued_mark[t] = 1'b1;
        end
      end
      rrq_pkg::KIND_ADD: begin
        if (queued_mark[t]) begin
          res.status = rrq_pkg::ST_QUEUED;
        end else begin
          sched_mark[t] = 1'b1;
          if (!not_empty) begin
            tail_id = t;
            not_empty = 1'b1;
          end else begin
            link_mem[t] = head_id;
          end
          head_id = t;
          queued_mark[t] = 1'b1;
        end
      end
      default: begin
        // remove: clear the mark, then unlink at the head or after walking from it
        sched_mark[t] = 1'b0;
        res.status = rrq_pkg::ST_NOT_FOUND;
        if (not_empty && queued_mark[t]) begin
          if (t == head_id) begin
            if (head_id == tail_id) begin
              not_empty = 1'b0;
              head_id = '0;
              tail_id = '0;
            end else begin
              head_id = link_mem[t];
            end
            queued_mark[t] = 1'b0;
            res.status = rrq_pkg::ST_DONE;
          end else begin
            prev = head_id;
            for (int n = 0; n < rrq_pkg::MAX_THREADS; n++) begin
              if (prev == tail_id) break;
              nx = link_mem[prev];
              if (nx == t) begin
                if (t == tail_id) tail_id = prev;
                else link_mem[prev] = link_mem[t];
                queued_mark[t] = 1'b0;
                res.status = rrq_pkg::ST_DONE;
                break;
              end
              prev = nx;
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic int draw_wait(bit steady);
    if (steady) return 0;
    return $urandom_range(0, 10);
  endfunction

  task automatic queue_request(logic [1:0] kind, int tid, bit drain = 1'b0);
    request_t r;
    r.req.kind = kind;
    r.req.thread_id = tid[rrq_pkg::TID_W-1:0];
    r.drain = drain;
    requests.push_back(r);
  endtask

  function automatic logic [1:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return rrq_pkg::KIND_NEXT;
    if (r < 55) return rrq_pkg::KIND_RETURN;
    if (r < 78) return rrq_pkg::KIND_ADD;
    return rrq_pkg::KIND_REMOVE;
  endfunction

  // driver: present requests with random gaps, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        due_results.push_back(run_queue_step(in_data));
        accepted <= accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (requests.size() != 0 &&
                     !(requests[0].drain && due_results.size() != 0)) begin
          in_valid <= 1'b1;
          in_data <= requests[0].req;
          requests.pop_front();
          if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
          in_gap <= draw_wait(in_steady);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, compare each result with the oldest prediction
  always @(posedge clk) begin
    rrq_pkg::out_item_t want;
    int                 stall;
    if (rst) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else if (out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (out_data.has_thread !== want.has_thread) begin
          $display("%0t: has_thread expected %0d actual %0d",
                   $time, want.has_thread, out_data.has_thread);
          errors++;
        end
        if (out_data.out_thread !== want.out_thread) begin
          $display("%0t: out_thread expected %0d actual %0d",
                   $time, want.out_thread, out_data.out_thread);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, out_data.status);
          errors++;
        end
      end
      if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
      stall = draw_wait(out_steady);
      if (stall != 0) begin
        out_ready <= 1'b0;
        out_stall <= stall;
      end
    end else if (!out_ready) begin
      if (out_stall <= 1) out_ready <= 1'b1;
      out_stall <= out_stall - 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, due_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int pool[16];
    int pool_size;
    int seg_len;
    int r;
    int n;

    for (int i = 0; i < rrq_pkg::MAX_THREADS; i++) begin
      link_mem[i] = '0;
      sched_mark[i] = 1'b0;
      queued_mark[i] = 1'b0;
    end

    // directed: empty queue, unscheduled, duplicates, head/tail/inner removal
    queue_request(rrq_pkg::KIND_NEXT, 63);     // take-next on empty queue
    queue_request(rrq_pkg::KIND_RETURN, 5);    // return of unscheduled thread
    queue_request(rrq_pkg::KIND_REMOVE, 7);    // remove of thread not queued
    queue_request(rrq_pkg::KIND_ADD, 0);
    queue_request(rrq_pkg::KIND_ADD, 63);
    queue_request(rrq_pkg::KIND_ADD, 63);      // add of queued thread
    queue_request(rrq_pkg::KIND_RETURN, 0);    // return of queued thread
    queue_request(rrq_pkg::KIND_ADD, 10);
    queue_request(rrq_pkg::KIND_ADD, 20);      // list: 20 10 63 0
    queue_request(rrq_pkg::KIND_REMOVE, 0);    // tail moves back to 63
    queue_request(rrq_pkg::KIND_REMOVE, 10);   // inner thread
    queue_request(rrq_pkg::KIND_REMOVE, 20);   // head
    queue_request(rrq_pkg::KIND_RETURN, 0);    // mark was cleared by remove
    queue_request(rrq_pkg::KIND_NEXT, 0, 1'b1); // pops last element after a drain
    queue_request(rrq_pkg::KIND_RETURN, 63);   // popped thread keeps its mark
    queue_request(rrq_pkg::KIND_ADD, 1);
    queue_request(rrq_pkg::KIND_NEXT, 0);
    queue_request(rrq_pkg::KIND_NEXT, 0);
    queue_request(rrq_pkg::KIND_NEXT, 0);
    queue_request(rrq_pkg::KIND_RETURN, 1);
    queue_request(rrq_pkg::KIND_RETURN, 63);
    queue_request(rrq_pkg::KIND_REMOVE, 63);   // tail
    queue_request(rrq_pkg::KIND_REMOVE, 1);    // only element
    queue_request(rrq_pkg::KIND_REMOVE, 1);

    // random: mostly small working sets, some long lists, some noise
    n = 0;
    while (n < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        pool_size = $urandom_range(4, 16);
        for (int i = 0; i < pool_size; i++) pool[i] = $urandom_range(0, 63);
        seg_len = $urandom_range(20, 60);
        for (int i = 0; i < seg_len; i++) begin
          if ($urandom_range(0, 99) < 85)
            queue_request(pick_kind(), pool[$urandom_range(0, pool_size - 1)],
                          n == 0 && i == 0);
          else
            queue_request(pick_kind(), $urandom_range(0, 63), n == 0 && i == 0);
        end
      end else if (r < 85) begin
        // grow a long list, then remove and rotate at random depths
        seg_len = $urandom_range(16, 64);
        for (int i = 0; i < seg_len; i++)
          queue_request(rrq_pkg::KIND_ADD, $urandom_range(0, 63), i == 0);
        for (int i = 0; i < seg_len; i++) begin
          r = $urandom_range(0, 99);
          if (r < 60) queue_request(rrq_pkg::KIND_REMOVE, $urandom_range(0, 63));
          else if (r < 80) queue_request(rrq_pkg::KIND_RETURN, $urandom_range(0, 63));
          else queue_request(rrq_pkg::KIND_NEXT, $urandom_range(0, 63));
        end
        seg_len = seg_len * 2;
      end else begin
        seg_len = $urandom_range(10, 30);
        for (int i = 0; i < seg_len; i++)
          queue_request(2'($urandom_range(0, 3)), $urandom_range(0, 63));
      end
      n += seg_len;
    end
    total_requests = requests.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (accepted != total_requests || due_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
